// ----- rtl/uart_remote_flash_requester_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the remote flash requester
// Each macro expects clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef UART_REMOTE_FLASH_REQUESTER_UNIT_DEFINES_SVH
`define UART_REMOTE_FLASH_REQUESTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define URFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define URFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/urfr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urfr_pkg
// Types and constants of the remote flash requester.
// ---------------------------------------------------------------------------
package urfr_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam int CHUNK_SIZE_DEF = 32;

	localparam logic [7:0] HDR_BYTE  = 8'h57;
	localparam logic [7:0] KEEP_BYTE = 8'h4B;
	localparam logic [7:0] ACK_BYTE  = 8'h06;
	localparam logic [7:0] NAK_BYTE  = 8'h07;

	// header bytes that follow the leading 'W'
	localparam logic [3:0] HDR_TAIL = 4'd9;

	localparam logic [23:0] ACK_WAIT_RST   = 24'd300000;
	localparam logic [31:0] CHUNK_WAIT_RST = 32'd3000000;

	// configuration register indexes
	localparam logic [0:0] REG_ACK_WAIT   = 1'b0;
	localparam logic [0:0] REG_CHUNK_WAIT = 1'b1;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_READ    = 3'd1,
		OP_ERASE   = 3'd2,
		OP_KEEP    = 3'd3,
		OP_RX      = 3'd4,
		OP_PAYLOAD = 3'd5,
		OP_TICK    = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ACK = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ACK1    = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_ACK2    = 3'd3,
		PH_RDWAIT  = 3'd4,
		PH_RDDRAIN = 3'd5
	} phase_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       done;
		status_t    status;
		logic       busy;
		logic       last;
	} res_t;

endpackage

// ----- rtl/uart_remote_flash_requester_unit.sv -----
`timescale 1ns / 1ps
// Path: the first result of an item goes through the input register, then the result register.
// Throughput: one item per cycle while the result register is not stalled; a start item holds
// the input while the header shift register sends the rest of its ten bytes.
// Reset: control state, pointers and counters clear and limits return to their reset values
// at once (arst_n low); FIFO contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// uart_remote_flash_requester_unit
// Requester for flash on a remote machine over a UART byte link: sends
// headers and payload, waits for acknowledges, drains read data in chunks.
// ---------------------------------------------------------------------------
module uart_remote_flash_requester_unit
	import urfr_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
	parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] address,
	input  logic [31:0] length,
	input  logic [7:0]  value,
	// result item channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        done_res,
	output logic [1:0]  status,
	output logic        busy_res,
	output logic        last
);

	localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNTW = $clog2(FIFO_DEPTH + 1);
	localparam int SZW  = $clog2(CHUNK_SIZE + 1);
	localparam int CMPW = (CNTW > SZW) ? CNTW : SZW;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [23:0] ack_wait_limit_q;
	logic [31:0] chunk_wait_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_wait_limit_q   <= ACK_WAIT_RST;
			chunk_wait_limit_q <= CHUNK_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACK_WAIT:   ack_wait_limit_q   <= cfg_data[23:0];
				REG_CHUNK_WAIT: chunk_wait_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake control
	// ---------------------------------------------------------------
	logic       valid_s1;
	opcode_t    opcode_s1;
	logic [31:0] address_s1;
	logic [31:0] length_s1;
	logic [7:0] value_s1;

	logic       out_valid_q;
	logic [71:0] hdr_q;
	logic [3:0] hdr_cnt_q;

	logic out_free;
	logic hdr_busy;
	logic go_s1;
	logic in_accept;

	// The result register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	// Header bytes still waiting to go out own the result register.
	assign hdr_busy  = (hdr_cnt_q != 4'd0);
	assign go_s1     = valid_s1 && out_free && !hdr_busy;
	assign in_stall  = valid_s1 && !go_s1;
	assign in_accept = in_valid && !in_stall;

	// Input register: hold the item until it can be processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1  <= opcode_t'(opcode);
			address_s1 <= address;
			length_s1  <= length;
			value_s1   <= value;
		end
	end

	// ---------------------------------------------------------------
	// Receive FIFO: memory with registered read of the head entry
	// ---------------------------------------------------------------
	logic [7:0]      fifo_mem [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW-1:0]   rd_ptr_d;
	logic [CNTW-1:0] count_q;
	logic [7:0]      mem_rd_q;
	logic            byp_q;
	logic [7:0]      byp_data_q;
	logic [7:0]      head;
	logic            push;
	logic            pop;

	assign rd_ptr_d = !pop ? rd_ptr_q :
		(rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

	// Bypass a write into the entry that becomes the head next cycle.
	assign head = byp_q ? byp_data_q : mem_rd_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= value_s1;
		end
		mem_rd_q   <= fifo_mem[rd_ptr_d];
		byp_q      <= push && (wr_ptr_q == rd_ptr_d);
		byp_data_q <= value_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
				count_q  <= count_q + CNTW'(1);
			end else if (pop) begin
				count_q  <= count_q - CNTW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Protocol state
	// ---------------------------------------------------------------
	phase_t         phase_q;
	phase_t         phase_d;
	logic [1:0]     cur_op_q;
	logic [1:0]     cur_op_d;
	logic [31:0]    bytes_left_q;
	logic [31:0]    bytes_left_d;
	logic [SZW-1:0] chunk_left_q;
	logic [SZW-1:0] chunk_left_d;
	logic [31:0]    wait_timer_q;
	logic [31:0]    wait_timer_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cur_op_q     <= 2'd0;
			bytes_left_q <= '0;
			chunk_left_q <= '0;
			wait_timer_q <= '0;
		end else if (go_s1) begin
			phase_q      <= phase_d;
			cur_op_q     <= cur_op_d;
			bytes_left_q <= bytes_left_d;
			chunk_left_q <= chunk_left_d;
			wait_timer_q <= wait_timer_d;
		end
	end

	// ---------------------------------------------------------------
	// Next state and first result of the item in the input register
	// ---------------------------------------------------------------
	res_t           res;
	logic           hdr_load;
	logic           fifo_push;
	logic           fifo_pop;
	logic [31:0]    timer_inc;
	logic [31:0]    bytes_dec;
	logic [SZW-1:0] chunk_sz;
	logic [SZW-1:0] chunk_now;
	logic [SZW-1:0] chunk_dec;
	logic           chunk_ready;

	assign push = go_s1 && fifo_push;
	assign pop  = go_s1 && fifo_pop;

	always_comb begin
		phase_d      = phase_q;
		cur_op_d     = cur_op_q;
		bytes_left_d = bytes_left_q;
		chunk_left_d = chunk_left_q;
		wait_timer_d = wait_timer_q;
		res          = '0;
		hdr_load     = 1'b0;
		fifo_push    = 1'b0;
		fifo_pop     = 1'b0;

		timer_inc = wait_timer_q + 32'd1;
		bytes_dec = bytes_left_q - 32'd1;
		// next chunk: the rest of the read, at most one chunk
		chunk_sz  = (bytes_left_q < 32'(CHUNK_SIZE)) ? SZW'(bytes_left_q) : SZW'(CHUNK_SIZE);
		chunk_ready = CMPW'(count_q) >= CMPW'(chunk_sz);
		chunk_now = (phase_q == PH_RDWAIT) ? chunk_sz : chunk_left_q;
		chunk_dec = chunk_now - SZW'(1);

		unique case (opcode_s1) inside
			OP_WRITE, OP_READ, OP_ERASE: begin
				if (phase_q == PH_IDLE) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = HDR_BYTE;
					hdr_load     = 1'b1;
					cur_op_d     = opcode_s1[1:0];
					bytes_left_d = length_s1;
					chunk_left_d = '0;
					wait_timer_d = '0;
					phase_d      = PH_ACK1;
				end
			end
			OP_KEEP: begin
				if (phase_q == PH_IDLE) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = KEEP_BYTE;
					cur_op_d     = 2'd3;
					bytes_left_d = '0;
					chunk_left_d = '0;
					wait_timer_d = '0;
					phase_d      = PH_ACK1;
				end
			end
			OP_RX: begin
				// drop the byte when the FIFO is full
				fifo_push = (count_q < CNTW'(FIFO_DEPTH));
			end
			OP_PAYLOAD: begin
				if (phase_q == PH_PAYLOAD) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = value_s1;
					bytes_left_d = bytes_dec;
					if (bytes_dec == 32'd0) begin
						wait_timer_d = '0;
						phase_d      = PH_ACK2;
					end
				end
			end
			OP_TICK: begin
				unique case (phase_q) inside
					PH_ACK1, PH_ACK2: begin
						if (count_q != '0) begin
							fifo_pop     = 1'b1;
							wait_timer_d = '0;
							if (head != ACK_BYTE) begin
								res.done   = 1'b1;
								res.status = ST_BAD_ACK;
								phase_d    = PH_IDLE;
							end else if (phase_q == PH_ACK2 || cur_op_q[1]) begin
								// erase, keepalive, or second acknowledge of a write
								res.done = 1'b1;
								phase_d  = PH_IDLE;
							end else if (cur_op_q == 2'd0) begin
								phase_d = (bytes_left_q == 32'd0) ? PH_ACK2 : PH_PAYLOAD;
							end else if (bytes_left_q == 32'd0) begin
								res.done = 1'b1;
								phase_d  = PH_IDLE;
							end else begin
								phase_d = PH_RDWAIT;
							end
						end else begin
							wait_timer_d = timer_inc;
							if (timer_inc >= {8'd0, ack_wait_limit_q}) begin
								wait_timer_d = '0;
								res.done     = 1'b1;
								res.status   = ST_TIMEOUT;
								phase_d      = PH_IDLE;
							end
						end
					end
					PH_RDWAIT, PH_RDDRAIN: begin
						if (phase_q == PH_RDDRAIN || chunk_ready) begin
							// deliver one buffered byte of the chunk
							fifo_pop       = 1'b1;
							res.data_valid = 1'b1;
							res.data_byte  = head;
							bytes_left_d   = bytes_dec;
							chunk_left_d   = chunk_dec;
							phase_d        = PH_RDDRAIN;
							if (chunk_dec == '0) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = ACK_BYTE;
								wait_timer_d = '0;
								if (bytes_dec == 32'd0) begin
									res.done = 1'b1;
									phase_d  = PH_IDLE;
								end else begin
									phase_d = PH_RDWAIT;
								end
							end
						end else begin
							wait_timer_d = timer_inc;
							if (timer_inc >= chunk_wait_limit_q) begin
								wait_timer_d = '0;
								res.tx_valid = 1'b1;
								res.tx_byte  = NAK_BYTE;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		res.busy = (phase_d != PH_IDLE);
		// a start leaves nine header bytes to follow
		res.last = !hdr_load;
	end

	// ---------------------------------------------------------------
	// Result register and header serializer
	// ---------------------------------------------------------------
	logic hdr_shift;
	logic out_load;
	res_t hdr_res;
	res_t out_q;

	assign hdr_shift = hdr_busy && out_free;
	assign out_load  = hdr_shift || go_s1;

	always_comb begin
		hdr_res          = '0;
		hdr_res.tx_valid = 1'b1;
		hdr_res.tx_byte  = hdr_q[7:0];
		hdr_res.busy     = 1'b1;
		hdr_res.last     = (hdr_cnt_q == 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hdr_cnt_q   <= 4'd0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (hdr_shift) begin
				hdr_cnt_q <= hdr_cnt_q - 4'd1;
			end else if (go_s1 && hdr_load) begin
				hdr_cnt_q <= HDR_TAIL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_shift) begin
			out_q <= hdr_res;
			hdr_q <= {8'h00, hdr_q[71:8]};
		end else if (go_s1) begin
			out_q <= res;
			if (hdr_load) begin
				// opcode byte, then address and length, little-endian
				hdr_q <= {length_s1, address_s1, 6'd0, opcode_s1[1:0] + 2'd1};
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign tx_valid   = out_q.tx_valid;
	assign tx_byte    = out_q.tx_byte;
	assign data_valid = out_q.data_valid;
	assign data_byte  = out_q.data_byte;
	assign done_res   = out_q.done;
	assign status     = out_q.status;
	assign busy_res   = out_q.busy;
	assign last       = out_q.last;

endmodule

// ----- rtl/urfr_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urfr_checker
// Port-level checks of the remote flash requester, bound to the top level.
// ---------------------------------------------------------------------------
`include "uart_remote_flash_requester_unit_defines.svh"

module urfr_checker
	import urfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       data_valid,
	input logic       done_res,
	input logic [1:0] status,
	input logic       busy_res,
	input logic       last
);

	// status is only meaningful on a finishing item
	`URFR_ASSERT_NOW(a_status_done, out_valid && !done_res, status == ST_OK, "status without done")
	// a finished operation leaves the block idle
	`URFR_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done while busy")
	// a byte sent together with read data is the chunk acknowledge
	`URFR_ASSERT_NOW(a_chunk_ack, out_valid && data_valid && tx_valid, tx_byte == ACK_BYTE, "chunk ack byte wrong")
	// a stalled result holds its place in the item sequence
	`URFR_ASSERT_NEXT(a_hold_last, out_valid && out_stall, out_valid && $stable(last), "stalled result changed")

endmodule

bind uart_remote_flash_requester_unit urfr_checker u_urfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.tx_valid   (tx_valid),
	.tx_byte    (tx_byte),
	.data_valid (data_valid),
	.done_res   (done_res),
	.status     (status),
	.busy_res   (busy_res),
	.last       (last)
);
